>>> rtl/b32c_pkg.sv
// base32 codec package: word types, alphabet and symbol helpers
// used by b32c_unit, b32c_drain and base32_codec_core; no dependencies
`timescale 1ns / 1ps

package b32c_pkg;

   localparam int unsigned MaxResults = 3;
   localparam int unsigned AccWidth   = 15;

   // ascii codes that bound the alphabet ranges
   localparam logic [7:0] CharUpperA = 8'h41;
   localparam logic [7:0] CharUpperZ = 8'h5A;
   localparam logic [7:0] CharLowerA = 8'h61;
   localparam logic [7:0] CharLowerZ = 8'h7A;
   localparam logic [7:0] CharDigit2 = 8'h32;
   localparam logic [7:0] CharDigit7 = 8'h37;
   localparam logic [4:0] DigitBase  = 5'd26;

   localparam logic DirEncode = 1'b0;
   localparam logic DirDecode = 1'b1;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       last_in;
   } req_word_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       message_end;
   } rsp_word_type;

   typedef struct packed {
      logic [6:0] bit_buffer;
      logic [2:0] bit_count;
   } state_type;

   // up to three results made by one input word
   typedef struct packed {
      logic [1:0]                    count;
      logic [MaxResults-1:0][7:0]    data;
      logic                          last;
   } group_type;

   // symbol value to alphabet character
   function automatic logic [7:0] alphabet_char(logic [4:0] v);
      logic [7:0] c;
      if (v < DigitBase) begin
         c = CharUpperA + {3'b000, v};
      end else begin
         c = CharDigit2 + {3'b000, v - DigitBase};
      end
      return c;
   endfunction

   // character to {valid, symbol}
   function automatic logic [5:0] symbol_of(logic [7:0] c);
      logic [7:0] d;
      logic [5:0] s;
      d = 8'd0;
      s = 6'd0;
      if (c >= CharUpperA && c <= CharUpperZ) begin
         d = c - CharUpperA;
         s = {1'b1, d[4:0]};
      end else if (c >= CharLowerA && c <= CharLowerZ) begin
         d = c - CharLowerA;
         s = {1'b1, d[4:0]};
      end else if (c >= CharDigit2 && c <= CharDigit7) begin
         d = c - CharDigit2;
         s = {1'b1, d[4:0] + DigitBase};
      end
      return s;
   endfunction

   function automatic logic [AccWidth-1:0] low_mask(logic [3:0] n);
      return (AccWidth'(1) << n) - AccWidth'(1);
   endfunction

endpackage

>>> rtl/b32c_unit.sv
// base32 codec datapath: one input word plus pending bits to a result group
// depends on b32c_pkg
`timescale 1ns / 1ps

module b32c_unit (
   input  logic                  direction,
   input  b32c_pkg::state_type   state_cur,
   input  b32c_pkg::req_word_type word_in,
   output b32c_pkg::group_type   group_out,
   output b32c_pkg::state_type   state_nxt
);
   import b32c_pkg::*;

   logic [AccWidth-1:0] acc;
   logic [AccWidth-1:0] rem_bits;
   logic [3:0]          total;
   logic [3:0]          rem;
   logic [5:0]          sym;

   always_comb begin
      group_out = '0;
      acc       = '0;
      total     = '0;
      rem       = {1'b0, state_cur.bit_count};
      rem_bits  = AccWidth'(state_cur.bit_buffer) & low_mask(rem);
      sym       = symbol_of(word_in.in_byte);
      group_out.last = word_in.last_in;

      if (direction == DirEncode) begin
         acc   = ((AccWidth'(state_cur.bit_buffer) & low_mask(rem)) << 8)
                 | AccWidth'(word_in.in_byte);
         total = {1'b0, state_cur.bit_count} + 4'd8;
         group_out.data[0] = alphabet_char(5'(acc >> (total - 4'd5)));
         if (total >= 4'd10) begin
            group_out.data[1] = alphabet_char(5'(acc >> (total - 4'd10)));
            group_out.count   = 2'd2;
            rem               = total - 4'd10;
         end else begin
            group_out.count   = 2'd1;
            rem               = total - 4'd5;
         end
         rem_bits = acc & low_mask(rem);
         // flush the tail, left-aligned and zero-filled
         if (word_in.last_in && rem != 4'd0) begin
            group_out.data[group_out.count] =
               alphabet_char(5'(rem_bits << (4'd5 - rem)));
            group_out.count = group_out.count + 2'd1;
         end
      end else if (sym[5]) begin
         acc   = ((AccWidth'(state_cur.bit_buffer) & low_mask(rem)) << 5)
                 | AccWidth'(sym[4:0]);
         total = {1'b0, state_cur.bit_count} + 4'd5;
         if (total >= 4'd8) begin
            group_out.data[0] = 8'(acc >> (total - 4'd8));
            group_out.count   = 2'd1;
            rem               = total - 4'd8;
         end else begin
            rem               = total;
         end
         rem_bits = acc & low_mask(rem);
      end

      if (word_in.last_in) begin
         state_nxt = '0;
      end else begin
         state_nxt.bit_count  = rem[2:0];
         state_nxt.bit_buffer = rem_bits[6:0];
      end
   end

endmodule

>>> rtl/b32c_drain.sv
// base32 codec result register: holds one group and hands it out a word at a time
// depends on b32c_pkg
`timescale 1ns / 1ps

module b32c_drain (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  b32c_pkg::group_type   group_in,
   output logic                  free,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output b32c_pkg::rsp_word_type rsp_word
);
   import b32c_pkg::*;

   group_type  group_ff, group_in_d;
   logic       valid_ff, valid_in;
   logic [1:0] ptr_ff, ptr_in;
   logic       final_word;

   assign final_word = (ptr_ff == group_ff.count - 2'd1);
   assign free       = !valid_ff || (rsp_ready && final_word);

   assign rsp_valid            = valid_ff;
   assign rsp_word.out_byte    = group_ff.data[ptr_ff];
   assign rsp_word.run_last    = final_word;
   assign rsp_word.message_end = final_word && group_ff.last;

   always_comb begin
      valid_in   = valid_ff;
      ptr_in     = ptr_ff;
      group_in_d = group_ff;
      if (load) begin
         valid_in   = (group_in.count != 2'd0);
         ptr_in     = 2'd0;
         group_in_d = group_in;
      end else if (valid_ff && rsp_ready) begin
         if (final_word) begin
            valid_in = 1'b0;
         end else begin
            ptr_in = ptr_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         ptr_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         ptr_ff   <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      group_ff <= group_in_d;
   end

endmodule

>>> rtl/base32_codec_core.sv
// base32 codec top level: input register, bit accumulator, result drain
// depends on b32c_pkg, b32c_unit, b32c_drain
`timescale 1ns / 1ps

//  channel | ports                          | moves
//  --------+--------------------------------+------------------------------------
//  req     | req_valid, req_ready, req_word | one byte or character per word
//  rsp     | rsp_valid, rsp_ready, rsp_word | one character or byte per word
//  csr     | csr_write_en, csr_write_data   | direction bit, 0 encode, 1 decode
//
//  a word waits in the input register until the result register is free, then its 0 to 3
//  results are loaded as a group into the result register, which drives rsp
//  the result register sends one word per cycle while rsp_ready is high and
//  takes the next group as its last word leaves
//  rsp stalls back up into the input register and then drop req_ready
//  reset (synchronous) clears both registers' valid flags, the pending bits and
//  selects encode; a csr write also clears the pending bits

module base32_codec_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  b32c_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output b32c_pkg::rsp_word_type rsp_word,
   input  logic                   csr_write_en,
   input  logic                   csr_write_data
);
   import b32c_pkg::*;

   // input register
   logic         in_valid_ff, in_valid_in;
   req_word_type in_word_ff, in_word_in;

   // direction and pending bits
   logic         dir_ff, dir_in;
   state_type    state_ff, state_in;

   state_type    state_nxt;
   group_type    group;
   logic         drain_free;
   logic         advance;

   // the input word moves on whenever the result register can take its group
   assign advance   = in_valid_ff && drain_free;
   assign req_ready = !in_valid_ff || drain_free;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_word_in  = in_word_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_word_in  = req_word;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // csr writes must only come while idle, never meeting an advance; the block does not enforce it
   always_comb begin
      dir_in   = dir_ff;
      state_in = state_ff;
      if (csr_write_en) begin
         dir_in   = csr_write_data;
         state_in = '0;
      end else if (advance) begin
         state_in = state_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         dir_ff      <= DirEncode;
         state_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         dir_ff      <= dir_in;
         state_ff    <= state_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      in_word_ff <= in_word_in;
   end

   // bit accumulator and character mapping
   b32c_unit u_unit (
      .direction (dir_ff),
      .state_cur (state_ff),
      .word_in   (in_word_ff),
      .group_out (group),
      .state_nxt (state_nxt)
   );

   // result register, one word out per cycle while rsp_ready is high
   b32c_drain u_drain (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .group_in  (group),
      .free      (drain_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule

>>> bench/base32_codec_core_test.sv
// self-checking bench for base32_codec_core: streams bytes and characters in both directions
// and checks every result word against an in-bench prediction; depends on b32c_pkg
`timescale 1ns / 1ps

module base32_codec_core_test;
   import b32c_pkg::*;

   localparam int QUIET_CYCLES   = 8;     // covers the input and result registers with margin
   localparam int WATCHDOG_LIMIT = 5000;  // cycles with no handshake before giving up
   localparam int HOLD_CYCLES    = 240;   // long receiver hold-off in the backpressure test

   // alphabet packed msb first, character i sits at bits [8*(31-i) +: 8]
   localparam logic [255:0] B32_ALPHABET = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_word;
   logic         csr_write_en;
   logic         csr_write_data;

   // predicted copy of the block's state and direction
   logic         codec_dir  = DirEncode;
   logic [6:0]   held_bits  = '0;
   logic [2:0]   held_count = '0;

   // result words still owed by the block, oldest first
   rsp_word_type code_queue[$];

   int           mismatch_count = 0;
   int           quiet_cycles   = 0;

   // idle rate, stall rate and hold-off requests are set by the stimulus, hold_seen and hold_left by the receiver
   int           req_idle_pct  = 0;
   int           rsp_stall_pct = 0;
   int           hold_asked    = 0;
   int           hold_seen     = 0;
   int           hold_left     = 0;
   int           hold_length   = 0;

   base32_codec_core u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_word       (req_word),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_word       (rsp_word),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always #4 clock = ~clock;

   // ------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------

   function automatic logic [7:0] alphabet_at(input logic [4:0] sym);
      return B32_ALPHABET[8*(31-int'(sym)) +: 8];
   endfunction

   function automatic logic [15:0] low_bits(input logic [3:0] n);
      return (16'd1 << n) - 16'd1;
   endfunction

   // runs one accepted word through the predicted codec and queues its results
   function automatic void predict_codes(input req_word_type w);
      logic [15:0]  acc;
      logic [3:0]   cnt;
      logic [7:0]   diff;
      logic         sym_ok;
      rsp_word_type made [3];
      int           n;
      int           k;
      acc = {9'd0, held_bits};
      cnt = {1'b0, held_count};
      n = 0;
      diff = '0;
      sym_ok = 1'b1;
      for (k = 0; k < 3; k++) begin
         made[k] = '0;
      end
      if (codec_dir == DirEncode) begin
         // byte joins the accumulator, every full 5-bit group leaves as a character
         acc = (acc << 8) | {8'd0, w.in_byte};
         cnt = cnt + 4'd8;
         while (cnt >= 4'd5) begin
            cnt = cnt - 4'd5;
            made[n].out_byte = alphabet_at(5'(acc >> cnt));
            n++;
            acc = acc & low_bits(cnt);
         end
         // end of message: leftover bits go out left-aligned, zero-filled
         if (w.last_in && cnt != 4'd0) begin
            made[n].out_byte = alphabet_at(5'(acc << (4'd5 - cnt)));
            n++;
         end
      end else begin
         // either letter case decodes the same, anything outside the alphabet is dropped
         if (w.in_byte >= "A" && w.in_byte <= "Z") begin
            diff = w.in_byte - "A";
         end else if (w.in_byte >= "a" && w.in_byte <= "z") begin
            diff = w.in_byte - "a";
         end else if (w.in_byte >= "2" && w.in_byte <= "7") begin
            diff = w.in_byte - "2" + 8'd26;
         end else begin
            sym_ok = 1'b0;
         end
         if (sym_ok) begin
            acc = (acc << 5) | {11'd0, diff[4:0]};
            cnt = cnt + 4'd5;
            if (cnt >= 4'd8) begin
               cnt = cnt - 4'd8;
               made[n].out_byte = 8'(acc >> cnt);
               n++;
               acc = acc & low_bits(cnt);
            end
         end
      end
      // last word of a message always leaves a clean accumulator
      if (w.last_in) begin
         acc = '0;
         cnt = '0;
      end
      held_count = cnt[2:0];
      held_bits  = acc[6:0];
      for (k = 0; k < n; k++) begin
         if (k == n - 1) begin
            made[k].run_last    = 1'b1;
            made[k].message_end = w.last_in;
         end
         code_queue.push_back(made[k]);
      end
   endfunction

   // ------------------------------------------------------------------
   // result side: receiver pacing, checking, watchdog
   // ------------------------------------------------------------------

   // rsp_ready pacing: a requested hold-off wins over the random stall rate
   always @(posedge clock) begin
      if (hold_seen != hold_asked) begin
         hold_seen <= hold_asked;
         hold_left <= hold_length;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic report_mismatch(input string what, input rsp_word_type got,
                                  input rsp_word_type want);
      mismatch_count++;
      // keep the log short when something goes badly wrong
      if (mismatch_count <= 40) begin
         $display("mismatch (%s) at %0t: got %h/%b/%b, want %h/%b/%b", what, $time,
                  got.out_byte, got.run_last, got.message_end,
                  want.out_byte, want.run_last, want.message_end);
      end
   endtask

   // each accepted result word is held against the oldest prediction
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (code_queue.size() == 0) begin
            report_mismatch("unexpected word", rsp_word, '0);
         end else begin
            want = code_queue.pop_front();
            if (rsp_word.out_byte !== want.out_byte) begin
               report_mismatch("out_byte", rsp_word, want);
            end
            if (rsp_word.run_last !== want.run_last) begin
               report_mismatch("run_last", rsp_word, want);
            end
            if (rsp_word.message_end !== want.message_end) begin
               report_mismatch("message_end", rsp_word, want);
            end
         end
      end
   end

   // no handshake on either side for the watchdog limit ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------

   // offers one word, idling first at the current rate, and predicts it once taken
   task automatic send_word(input logic [7:0] b, input logic last);
      req_word_type w;
      w.in_byte = b;
      w.last_in = last;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      predict_codes(w);
   endtask

   // stops offering and waits for every owed word, then lets any
   // result-free word still inside the block run out
   task automatic drain_results();
      req_valid <= 1'b0;
      while (code_queue.size() != 0) begin
         @(posedge clock);
      end
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // direction writes happen only with the block drained; they also clear the pending bits
   task automatic write_direction(input logic dir);
      drain_results();
      csr_write_en   <= 1'b1;
      csr_write_data <= dir;
      @(posedge clock);
      csr_write_en <= 1'b0;
      codec_dir  = dir;
      held_bits  = '0;
      held_count = '0;
      @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // all-ones byte alone, then a four-byte message whose last byte makes three characters
   task automatic test_encode_extremes();
      write_direction(DirEncode);
      req_idle_pct = 0;
      send_word(8'hFF, 1'b1);
      send_word(8'h00, 1'b0);
      send_word(8'hA5, 1'b0);
      send_word(8'h5A, 1'b0);
      send_word(8'hC3, 1'b1);
   endtask

   // range edges of both letter cases and the digits, their neighbors as noise,
   // then a message whose last character is noise and so yields nothing
   task automatic test_decode_alphabet();
      string probe;
      int    i;
      probe = "A@Z[az{2178M";
      write_direction(DirDecode);
      for (i = 0; i < probe.len(); i++) begin
         send_word(probe[i], 1'b0);
      end
      send_word(8'h60, 1'b0);   // just below lowercase a
      send_word(8'hFF, 1'b0);
      send_word("q", 1'b1);     // eighth symbol completes the fifth byte
      send_word("B", 1'b0);
      send_word(8'h00, 1'b1);   // noise as last word: no result, bits dropped
   endtask

   // pending bits must not survive a direction write
   task automatic test_direction_switch();
      write_direction(DirEncode);
      send_word(8'h3C, 1'b0);   // leaves three bits behind
      write_direction(DirDecode);
      write_direction(DirEncode);
      send_word(8'h81, 1'b1);
   endtask

   // random whole messages at one idle/stall setting; noise words in
   // decode do not count toward the goal
   task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                    input logic dir, input int goal);
      int         counted;
      int         msg_len;
      int         k;
      logic [7:0] b;
      write_direction(dir);
      req_idle_pct = idle_pct;
      rsp_stall_pct <= stall_pct;
      counted = 0;
      while (counted < goal) begin
         // mostly short messages, now and then a long one
         msg_len = ($urandom_range(9) == 0) ? $urandom_range(40, 16) : $urandom_range(8, 1);
         for (k = 0; k < msg_len; k++) begin
            if (dir == DirEncode) begin
               b = 8'($urandom);
               counted++;
            end else if ($urandom_range(9) == 0) begin
               b = 8'($urandom);
            end else begin
               b = alphabet_at(5'($urandom_range(31)));
               // letters go lowercase half the time
               if (b >= "A" && b <= "Z" && $urandom_range(1) == 1) begin
                  b = b | 8'h20;
               end
               counted++;
            end
            send_word(b, k == msg_len - 1);
         end
      end
   endtask

   // receiver holds off while the sender keeps offering until the block backs up,
   // then the sender waits for every owed word before carrying on
   task automatic test_backpressure();
      int k;
      write_direction(DirEncode);
      req_idle_pct = 0;
      rsp_stall_pct <= 0;
      hold_length <= HOLD_CYCLES;
      hold_asked  <= hold_asked + 1;
      for (k = 0; k < 20; k++) begin
         send_word(8'($urandom), $urandom_range(3) == 0);
      end
      drain_results();
      req_idle_pct = 24;
      rsp_stall_pct <= 24;
      for (k = 0; k < 10; k++) begin
         send_word(8'($urandom), k == 9 || $urandom_range(3) == 0);
      end
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_word       = '0;
      csr_write_en   = 1'b0;
      csr_write_data = DirEncode;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_encode_extremes();
      test_decode_alphabet();
      test_direction_switch();
      test_random_phase(0, 0, DirEncode, 45);
      test_random_phase(70, 0, DirDecode, 45);
      test_random_phase(0, 70, DirEncode, 45);
      test_random_phase(24, 24, DirDecode, 45);
      test_backpressure();

      drain_results();
      repeat (2 * QUIET_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && code_queue.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
